### rtl/core/blt_pkg.sv
// Shared types and constants for the blanking time lock tracker.
package blt_pkg;

	localparam int FAST_RATE_DEF = 8;
	localparam int VAL_W         = 16;
	localparam int ERR_W         = 18;
	localparam int ADDR_W        = 4;
	localparam int APB_DATA_W    = 32;
	localparam int S_TDATA_W     = 16;
	localparam int M_TDATA_W     = 40;

	localparam logic [VAL_W-1:0] HYST_RST      = 16'd16;
	localparam logic [VAL_W-1:0] BLANK_MIN_RST = 16'd100;
	localparam logic [VAL_W-1:0] BLANK_MAX_RST = 16'd5000;
	localparam logic [VAL_W-1:0] LOCKLOSS_RST  = 16'd50;

	typedef enum logic [1:0] {
		REG_HYST      = 2'd0,
		REG_BLANK_MIN = 2'd1,
		REG_BLANK_MAX = 2'd2,
		REG_LOCKLOSS  = 2'd3
	} blt_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} blt_op_t;

	typedef struct packed {
		logic [VAL_W-1:0] hyst;
		logic [VAL_W-1:0] blank_min;
		logic [VAL_W-1:0] blank_max;
		logic [VAL_W-1:0] lockloss;
	} blt_cfg_t;

	// packed from the lowest bit up: locked, filtered, held, gained, lost
	typedef struct packed {
		logic             lost;
		logic             gained;
		logic [VAL_W-1:0] held;
		logic [VAL_W-1:0] filtered;
		logic             locked;
	} blt_result_t;

endpackage

### rtl/core/blt_apb_regs.sv
// APB configuration registers of the tracker.
module blt_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blt_pkg::ADDR_W-1:0]     paddr,
	input  logic [blt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [blt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output blt_pkg::blt_cfg_t              cfg
);
	import blt_pkg::*;

	blt_cfg_t cfg_q;
	blt_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = blt_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hyst      <= HYST_RST;
			cfg_q.blank_min <= BLANK_MIN_RST;
			cfg_q.blank_max <= BLANK_MAX_RST;
			cfg_q.lockloss  <= LOCKLOSS_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_HYST:      cfg_q.hyst      <= pwdata[VAL_W-1:0];
				REG_BLANK_MIN: cfg_q.blank_min <= pwdata[VAL_W-1:0];
				REG_BLANK_MAX: cfg_q.blank_max <= pwdata[VAL_W-1:0];
				REG_LOCKLOSS:  cfg_q.lockloss  <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_HYST:      prdata[VAL_W-1:0] = cfg_q.hyst;
			REG_BLANK_MIN: prdata[VAL_W-1:0] = cfg_q.blank_min;
			REG_BLANK_MAX: prdata[VAL_W-1:0] = cfg_q.blank_max;
			REG_LOCKLOSS:  prdata[VAL_W-1:0] = cfg_q.lockloss;
			default:       prdata = '0;
		endcase
	end

endmodule

### rtl/core/blt_track.sv
// Tracker state and its combinational update for one request, registered when step is high.
module blt_track #(
	parameter int FAST_RATE = blt_pkg::FAST_RATE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  blt_pkg::blt_cfg_t         cfg,
	input  logic                      step,
	input  blt_pkg::blt_op_t          op,
	input  logic [blt_pkg::VAL_W-1:0] sample,
	output blt_pkg::blt_result_t      result
);
	import blt_pkg::*;

	// x / FAST_RATE == (x * RECIP) >> SHIFT exactly for every 16-bit x
	localparam int          SHIFT = VAL_W + $clog2(FAST_RATE);
	localparam logic [16:0] RECIP = 17'(((64'd1 << SHIFT) + 64'(FAST_RATE) - 64'd1)
		/ 64'(FAST_RATE));

	logic [VAL_W-1:0] filt_q, held_q;
	logic             locked_q;
	logic [ERR_W-1:0] err_q;

	logic [VAL_W-1:0] filt_d, held_d;
	logic             locked_d;
	logic [ERR_W-1:0] err_d;
	logic             gained, lost;

	logic [32:0]      f_prod, s_prod;
	logic [VAL_W-1:0] f_div, s_div;
	logic [VAL_W:0]   avg_sum;
	logic [VAL_W-1:0] avg;
	logic [VAL_W+1:0] conv_diff;
	logic [VAL_W:0]   conv_mag;
	logic             converged, in_range;

	logic [ERR_W:0]   esum;
	logic [ERR_W:0]   esum_abs;
	logic             trip;
	logic [VAL_W-1:0] nudged;
	logic [VAL_W:0]   dev, dev_abs;
	logic             drifted;

	assign f_prod = 33'(filt_q) * 33'(RECIP);
	assign s_prod = 33'(sample) * 33'(RECIP);
	assign f_div  = 16'(f_prod >> SHIFT);
	assign s_div  = 16'(s_prod >> SHIFT);

	// unlocked path: fast average, convergence test and range test
	assign avg_sum   = {1'b0, filt_q} - {1'b0, f_div} + {1'b0, s_div};
	assign avg       = avg_sum[VAL_W-1:0];
	assign conv_diff = {2'b00, avg} - {2'b00, sample};
	assign conv_mag  = conv_diff[VAL_W+1] ? 17'(-conv_diff) : conv_diff[VAL_W:0];
	assign converged = conv_mag < {1'b0, cfg.hyst};
	assign in_range  = (avg >= cfg.blank_min) && (avg <= cfg.blank_max);

	// locked path: error accumulator, saturating nudge, drift test
	assign esum     = {err_q[ERR_W-1], err_q} + {3'b000, sample} - {3'b000, filt_q};
	assign esum_abs = esum[ERR_W] ? -esum : esum;
	assign trip     = esum_abs > {3'b000, cfg.hyst};

	always_comb begin
		nudged = filt_q;
		if (trip) begin
			if (esum[ERR_W]) begin
				if (filt_q != '0) nudged = filt_q - 16'd1;
			end else begin
				if (filt_q != '1) nudged = filt_q + 16'd1;
			end
		end
	end

	assign dev     = {1'b0, nudged} - {1'b0, held_q};
	assign dev_abs = dev[VAL_W] ? -dev : dev;
	assign drifted = dev_abs > {1'b0, cfg.lockloss};

	always_comb begin
		filt_d   = filt_q;
		held_d   = held_q;
		locked_d = locked_q;
		err_d    = err_q;
		gained   = 1'b0;
		lost     = 1'b0;
		if (op == OP_CLEAR) begin
			filt_d   = '0;
			held_d   = '0;
			locked_d = 1'b0;
			err_d    = '0;
		end else if (!locked_q) begin
			filt_d = avg;
			if (converged) begin
				if (!in_range) begin
					// range failure keeps the accumulator
					filt_d = '0;
					held_d = '0;
					lost   = 1'b1;
				end else begin
					locked_d = 1'b1;
					held_d   = avg;
					err_d    = '0;
					gained   = 1'b1;
				end
			end
		end else begin
			filt_d = nudged;
			err_d  = trip ? '0 : esum[ERR_W-1:0];
			if (drifted) begin
				locked_d = 1'b0;
				lost     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q   <= '0;
			held_q   <= '0;
			locked_q <= 1'b0;
			err_q    <= '0;
		end else if (step) begin
			filt_q   <= filt_d;
			held_q   <= held_d;
			locked_q <= locked_d;
			err_q    <= err_d;
		end
	end

	assign result.locked   = locked_d;
	assign result.filtered = filt_d;
	assign result.held     = held_d;
	assign result.gained   = gained;
	assign result.lost     = lost;

endmodule

### rtl/core/blanking_time_lock_tracker_unit.sv
// Top level of the blanking time lock tracker: stream ports, APB registers, pipeline.
// A request is registered in the input stage (s1), its result in res_q.
// Throughput: one request per cycle unless m_tready stalls the output.
// Input and result registers let a request enter while a result waits on m_tready.
// Reset clears the pipeline and the tracker to unlocked zeros; registers take defaults.
module blanking_time_lock_tracker_unit #(
	parameter int FAST_RATE = blt_pkg::FAST_RATE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blt_pkg::ADDR_W-1:0]     paddr,
	input  logic [blt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [blt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [blt_pkg::S_TDATA_W-1:0]  s_tdata,  // [15:0] sample_us
	input  logic                           s_tuser,  // [0] opcode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] is_locked, [16:1] filtered_us, [32:17] held_us, [33] lock_gained,
	// [34] lock_lost, [39:35] zero
	output logic [blt_pkg::M_TDATA_W-1:0]  m_tdata
);
	import blt_pkg::*;

	blt_cfg_t         cfg;
	blt_result_t      res_next;
	blt_result_t      res_q;
	logic             out_valid_q;
	logic             valid_s1;
	blt_op_t          op_s1;
	logic [VAL_W-1:0] sample_s1;
	logic             advance;

	blt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	blt_track #(
		.FAST_RATE (FAST_RATE)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.op     (op_s1),
		.sample (sample_s1),
		.result (res_next)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= blt_op_t'(s_tuser);
			sample_s1 <= s_tdata[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, res_q};

	a_pulses_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.gained && res_q.lost))
		else $error("lock gained and lost in the same result");

	a_gain_holds_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.gained) |-> (res_q.locked && res_q.held == res_q.filtered))
		else $error("lock gained without capturing the filtered value");

	a_loss_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.lost) |-> !res_q.locked)
		else $error("lock lost but still reported locked");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_CLEAR) |=> (res_q.filtered == '0 && res_q.held == '0
			&& !res_q.locked && !res_q.gained && !res_q.lost))
		else $error("clear request did not report a cleared tracker");

endmodule
